/* sv/pba_pkg.sv */
// ----------------------------------------------------------------------------
// pba_pkg
// Shared constants for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;
    localparam int NUM_PAGES   = 1024;
    localparam int MAX_REQUEST = 64;
    localparam int MAP_BYTES   = (NUM_PAGES + 7) / 8;
    localparam int ADDR_W      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int PAGE_W      = 10;
    localparam int COUNT_W     = 7;
    localparam int PG_W        = ADDR_W + 3;
    localparam logic [PG_W-1:0] LAST_PG = PG_W'(NUM_PAGES - 1);

    localparam logic [1:0] MODE_CONTIG  = 2'd0;
    localparam logic [1:0] MODE_SCATTER = 2'd1;
    localparam logic [1:0] MODE_FREE    = 2'd2;
    localparam logic [1:0] MODE_MARK    = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_SHORT   = 2'd2;
endpackage

/* sv/page_bitmap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// page_bitmap_allocator_unit
// First-fit page allocator over a byte-wide page-use bitmap in block RAM.
// ----------------------------------------------------------------------------
// Free/mark read each byte touched (S_RD, S_WAIT), update its pages (S_RMW), write it back.
// Alloc walks the map one page per cycle in S_SCAN, pausing at each new byte for its read;
// a contiguous hit rewinds and marks the run in a second pass, and a scattered alloc waits
// in S_OUT at each result until it is taken. One request at a time; s_tready returns the
// cycle after the last result is taken, or after the last byte write for free/mark.
// Reset (aresetn low, synchronous) starts a clearing pass that zeroes all MAP_BYTES (128) bytes.
module page_bitmap_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // count[6:0], start_page[16:7]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // page[9:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);
    import pba_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;   // issue read of addr_reg
    localparam logic [2:0] S_WAIT  = 3'd3;   // read data lands
    localparam logic [2:0] S_SCAN  = 3'd4;   // bit walk over byte_reg
    localparam logic [2:0] S_RMW   = 3'd5;   // range update of byte_reg
    localparam logic [2:0] S_OUT   = 3'd6;   // hold result
    localparam logic [2:0] S_NEXT  = 3'd7;   // scatter: resume after a result

    logic [7:0]          mem [MAP_BYTES];
    logic [7:0]          rdata_reg;
    logic                we;
    logic [7:0]          wdata;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [7:0]          byte_reg, byte_next;
    logic [2:0]          bit_reg, bit_next;
    logic [1:0]          mode_reg, mode_next;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;       // requested count
    logic [COUNT_W-1:0]  run_reg, run_next;       // run length / found / left
    logic                fill_reg, fill_next;     // contig: marking pass
    logic                pend_vld_reg, pend_vld_next;   // scatter: page held back
    logic [PAGE_W-1:0]   pend_page_reg, pend_page_next;
    logic [PAGE_W-1:0]   o_page_reg, o_page_next;
    logic [1:0]          o_st_reg, o_st_next;
    logic                o_last_reg, o_last_next;
    logic                o_done_reg, o_done_next; // after output: finish request

    logic [1:0]          in_mode;
    logic [COUNT_W-1:0]  in_cnt;
    logic [PAGE_W-1:0]   in_start;
    logic [PG_W-1:0]     cur_pg;
    logic                cur_used;
    logic                at_end;
    logic [COUNT_W-1:0]  run_inc;
    logic [PG_W-1:0]     run_first;
    logic                adv;

    assign in_mode   = s_tuser;
    assign in_cnt    = (s_tdata[6:0] > COUNT_W'(MAX_REQUEST)) ?
                       COUNT_W'(MAX_REQUEST) : s_tdata[6:0];
    assign in_start  = s_tdata[16:7];
    assign cur_pg    = {addr_reg, bit_reg};
    assign cur_used  = byte_reg[bit_reg];
    assign at_end    = (cur_pg == LAST_PG);
    assign run_inc   = run_reg + COUNT_W'(1);
    assign run_first = cur_pg - PG_W'(cnt_reg) + PG_W'(1);

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr_reg] <= wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {6'd0, o_page_reg};
    assign m_tuser  = o_st_reg;
    assign m_tlast  = o_last_reg;

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        byte_next      = byte_reg;
        bit_next       = bit_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        run_next       = run_reg;
        fill_next      = fill_reg;
        pend_vld_next  = pend_vld_reg;
        pend_page_next = pend_page_reg;
        o_page_next    = o_page_reg;
        o_st_next      = o_st_reg;
        o_last_next    = o_last_reg;
        o_done_next    = o_done_reg;
        we             = 1'b0;
        wdata          = byte_reg;
        adv            = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                we    = 1'b1;
                wdata = 8'd0;
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(MAP_BYTES - 1)) begin
                    state_next = S_IDLE;
                    addr_next  = '0;
                end
            end
            S_IDLE: begin
                if (s_tvalid && in_cnt != '0) begin
                    mode_next     = in_mode;
                    cnt_next      = in_cnt;
                    fill_next     = 1'b0;
                    pend_vld_next = 1'b0;
                    if (in_mode == MODE_FREE || in_mode == MODE_MARK) begin
                        run_next  = in_cnt;
                        addr_next = ADDR_W'(in_start >> 3);
                        bit_next  = in_start[2:0];
                        if (int'(in_start) < NUM_PAGES) begin
                            state_next = S_RD;
                        end
                    end else begin
                        run_next   = '0;
                        addr_next  = '0;
                        bit_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD: state_next = S_WAIT;
            S_WAIT: begin
                byte_next  = rdata_reg;
                state_next = (mode_reg == MODE_FREE || mode_reg == MODE_MARK || fill_reg)
                             ? S_RMW : S_SCAN;
            end
            S_RMW: begin
                // set or clear bits from bit_reg while run_reg remains
                byte_next[bit_reg] = (mode_reg != MODE_FREE);
                run_next = run_reg - COUNT_W'(1);
                bit_next = bit_reg + 3'd1;
                if (run_reg == COUNT_W'(1) || at_end) begin
                    we         = 1'b1;
                    wdata      = byte_next;
                    addr_next  = '0;
                    state_next = fill_reg ? S_OUT : S_IDLE;
                end else if (bit_reg == 3'd7) begin
                    we         = 1'b1;
                    wdata      = byte_next;
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = S_RD;
                end
            end
            S_SCAN: begin
                if (mode_reg == MODE_CONTIG) begin
                    if (cur_used) begin
                        run_next = '0;
                        adv      = 1'b1;
                    end else if (run_inc == cnt_reg) begin
                        // found: rewind and mark the run
                        o_page_next = PAGE_W'(run_first);
                        o_st_next   = ST_OK;
                        o_last_next = 1'b1;
                        o_done_next = 1'b1;
                        fill_next   = 1'b1;
                        run_next    = cnt_reg;
                        addr_next   = run_first[PG_W-1:3];
                        bit_next    = run_first[2:0];
                        state_next  = S_RD;
                    end else begin
                        run_next = run_inc;
                        adv      = 1'b1;
                    end
                end else begin
                    // scattered: a found page is held until the next one shows
                    // whether it is the last
                    if (!cur_used) begin
                        byte_next[bit_reg] = 1'b1;
                        run_next       = run_inc;
                        pend_page_next = PAGE_W'(cur_pg);
                        pend_vld_next  = 1'b1;
                        if (pend_vld_reg) begin
                            o_page_next = pend_page_reg;
                            o_st_next   = ST_OK;
                            o_last_next = 1'b0;
                            o_done_next = 1'b0;
                            state_next  = S_OUT;
                        end else if (run_inc == cnt_reg) begin
                            we          = 1'b1;
                            wdata       = byte_next;
                            o_page_next = PAGE_W'(cur_pg);
                            o_st_next   = ST_OK;
                            o_last_next = 1'b1;
                            o_done_next = 1'b1;
                            state_next  = S_OUT;
                        end else begin
                            adv = 1'b1;
                        end
                    end else begin
                        adv = 1'b1;
                    end
                end
            end
            S_NEXT: begin
                if (run_reg == cnt_reg) begin
                    // request filled: the held page is the last
                    we          = 1'b1;
                    wdata       = byte_reg;
                    o_page_next = pend_page_reg;
                    o_st_next   = ST_OK;
                    o_last_next = 1'b1;
                    o_done_next = 1'b1;
                    state_next  = S_OUT;
                end else begin
                    adv = 1'b1;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = o_done_reg ? S_IDLE : S_NEXT;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // walk to the next page; write back a scatter byte when leaving it; at the map end, report short or no space
        if (adv) begin
            if (at_end) begin
                we          = (mode_reg == MODE_SCATTER);
                wdata       = byte_next;
                o_last_next = 1'b1;
                o_done_next = 1'b1;
                state_next  = S_OUT;
                if (pend_vld_next) begin
                    o_page_next = pend_page_next;
                    o_st_next   = ST_SHORT;
                end else begin
                    o_page_next = '0;
                    o_st_next   = ST_NOSPACE;
                end
            end else if (bit_reg == 3'd7) begin
                we         = (mode_reg == MODE_SCATTER);
                wdata      = byte_next;
                addr_next  = addr_reg + ADDR_W'(1);
                bit_next   = 3'd0;
                state_next = S_RD;
            end else begin
                bit_next   = bit_reg + 3'd1;
                state_next = S_SCAN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            fill_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            o_done_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            fill_reg     <= fill_next;
            pend_vld_reg <= pend_vld_next;
            o_done_reg   <= o_done_next;
        end
        byte_reg      <= byte_next;
        bit_reg       <= bit_next;
        mode_reg      <= mode_next;
        cnt_reg       <= cnt_next;
        run_reg       <= run_next;
        pend_page_reg <= pend_page_next;
        o_page_reg    <= o_page_next;
        o_st_reg      <= o_st_next;
        o_last_reg    <= o_last_next;
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> o_done_reg) else $error("last without done");
    a_nospace_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_NOSPACE) |-> (m_tdata == '0))
        else $error("no space with nonzero page");
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("result changed while stalled");
endmodule
